// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the edge table lookup.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define TEL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define TEL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tel_pkg.sv =====
// Package with the opcodes and shared types of the edge table lookup.
package tel_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    localparam int unsigned IDX_W  = 10;
    localparam int unsigned VERT_W = 16;

    // Flags that travel with an edge through the chain of match cells.
    typedef struct packed {
        logic valid;
        logic claimed;
        logic last;
    } t_tok_flags;

    // Control from the sequencer to every match cell.
    typedef struct packed {
        logic start;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/tel_intf.sv =====
// Handshake interfaces for the request and result channels.
interface tel_req_if
    import tel_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [VERT_W-1:0] vert_a;
    logic [VERT_W-1:0] vert_b;
    logic [VERT_W-1:0] vert_c;

    modport source (output valid, output op, output vert_a, output vert_b, output vert_c,
                    input ready);
    modport sink   (input valid, input op, input vert_a, input vert_b, input vert_c,
                    output ready);
endinterface

interface tel_rsp_if
    import tel_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] side0_edge;
    logic [IDX_W-1:0] side1_edge;
    logic [IDX_W-1:0] side2_edge;
    logic             side0_found;
    logic             side1_found;
    logic             side2_found;
    logic             overflow;

    modport source (output valid, output side0_edge, output side1_edge, output side2_edge,
                    output side0_found, output side1_found, output side2_found,
                    output overflow, input ready);
    modport sink   (input valid, input side0_edge, input side1_edge, input side2_edge,
                    input side0_found, input side1_found, input side2_found,
                    input overflow, output ready);
endinterface

// ===== hw/rtl/tel_ram.sv =====
// Generic single-port RAM with registered read data.
module tel_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tel_cell.sv =====
// Match cell: holds one triangle side and the best matching edge index for it.
module tel_cell
    import tel_pkg::*;
#(
    parameter int unsigned VERTEX_BITS = 16,
    parameter int unsigned ADDR_W      = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [VERTEX_BITS-1:0]   i_side_p,
    input  logic [VERTEX_BITS-1:0]   i_side_q,
    input  t_tok_flags               i_flags,
    input  logic [2*VERTEX_BITS-1:0] i_edge,
    input  logic [ADDR_W-1:0]        i_idx,
    output t_tok_flags               o_flags,
    output logic [2*VERTEX_BITS-1:0] o_edge,
    output logic [ADDR_W-1:0]        o_idx,
    output logic                     o_found,
    output logic [ADDR_W-1:0]        o_best
);

    logic [VERTEX_BITS-1:0]   r_p;
    logic [VERTEX_BITS-1:0]   r_q;
    logic                     r_found;
    logic [ADDR_W-1:0]        r_best;
    t_tok_flags               r_flags;
    logic [2*VERTEX_BITS-1:0] r_edge;
    logic [ADDR_W-1:0]        r_idx;

    logic [VERTEX_BITS-1:0] w_e0;
    logic [VERTEX_BITS-1:0] w_e1;
    logic                   w_hit;
    t_tok_flags             n_flags;

    assign w_e0 = i_edge[VERTEX_BITS-1:0];
    assign w_e1 = i_edge[2*VERTEX_BITS-1:VERTEX_BITS];

    // An edge already taken by an earlier side passes through untouched.
    assign w_hit = i_flags.valid && !i_flags.claimed &&
                   (((w_e0 == r_p) && (w_e1 == r_q)) || ((w_e1 == r_p) && (w_e0 == r_q)));

    always_comb begin
        n_flags         = i_flags;
        n_flags.claimed = i_flags.claimed || w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_found <= 1'b0;
        end else begin
            r_flags <= n_flags;
            if (i_ctl.start) begin
                r_found <= 1'b0;
            end else if (w_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge <= i_edge;
        r_idx  <= i_idx;
        if (i_ctl.start) begin
            r_p    <= i_side_p;
            r_q    <= i_side_q;
            r_best <= '0;
        end else if (w_hit) begin
            // Edges arrive in index order, so the latest hit is the highest index.
            r_best <= i_idx;
        end
    end

    assign o_flags = r_flags;
    assign o_edge  = r_edge;
    assign o_idx   = r_idx;
    assign o_found = r_found;
    assign o_best  = r_best;

endmodule

// ===== hw/rtl/triangle_edge_lookup.sv =====
// Clear and append complete in the idle state; a dropped append on a full table emits a result.
// A query runs the scan, flush and emit states; on an empty table it goes straight to emit.
// The query time is set by the single table RAM port, which delivers one edge per cycle.
// One item is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset empties the table and clears the control state.
// Table contents are not cleared by reset; only entries below the edge count are read.
`include "assert_macros.svh"

module triangle_edge_lookup
    import tel_pkg::*;
#(
    parameter int unsigned MAX_EDGES   = 1024,
    parameter int unsigned VERTEX_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tel_req_if.sink   i_req,
    tel_rsp_if.source o_rsp
);

    localparam int unsigned ADDR_W = $clog2(MAX_EDGES);
    localparam int unsigned CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int unsigned EDGE_W = 2 * VERTEX_BITS;
    localparam int unsigned NCELLS = 3;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic              r_pend_ovf;
    logic              n_pend_ovf;

    // Read tag, registered alongside the RAM's registered read so it lines up with the read data.
    logic              r_rd_valid;
    logic              r_rd_last;
    logic [ADDR_W-1:0] r_rd_idx;

    // Output register.
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_edge [NCELLS];
    logic [NCELLS-1:0] r_out_found;
    logic             r_out_ovf;

    // Input vertices narrowed or widened to the vertex width.
    logic [31:0]            w_a32;
    logic [31:0]            w_b32;
    logic [31:0]            w_c32;
    logic [VERTEX_BITS-1:0] w_va;
    logic [VERTEX_BITS-1:0] w_vb;
    logic [VERTEX_BITS-1:0] w_vc;

    logic              w_accept;
    logic              w_full;
    logic              w_scan_last;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_addr;
    logic [EDGE_W-1:0] w_ram_rdata;
    logic              w_emit_load;
    logic              w_tail_last;
    t_cell_ctl         w_ctl;

    // Chain links: stage k feeds cell k, stage k+1 is its output.
    t_tok_flags        w_flags [NCELLS+1];
    logic [EDGE_W-1:0] w_edge  [NCELLS];
    logic [ADDR_W-1:0] w_idx   [NCELLS];
    logic [VERTEX_BITS-1:0] w_side_p [NCELLS];
    logic [VERTEX_BITS-1:0] w_side_q [NCELLS];
    logic [NCELLS-1:0] w_found;
    logic [ADDR_W-1:0] w_best  [NCELLS];

    assign w_a32 = 32'(i_req.vert_a);
    assign w_b32 = 32'(i_req.vert_b);
    assign w_c32 = 32'(i_req.vert_c);
    assign w_va  = w_a32[VERTEX_BITS-1:0];
    assign w_vb  = w_b32[VERTEX_BITS-1:0];
    assign w_vc  = w_c32[VERTEX_BITS-1:0];

    // New items are taken only in the idle state; a waiting result does not block them.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(MAX_EDGES));
    assign w_scan_last = ((CNT_W'(r_addr) + CNT_W'(1)) == r_count);

    // The single RAM port writes appends while idle and reads edges while scanning.
    assign w_ram_we   = w_accept && (t_op'(i_req.op) == OP_APPEND) && !w_full;
    assign w_ram_addr = (r_state == S_IDLE) ? r_count[ADDR_W-1:0] : r_addr;

    tel_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata ({w_vb, w_va}),
        .o_rdata (w_ram_rdata)
    );

    // A query loads each cell with its side: v0-v1, v1-v2, v2-v0.
    assign w_ctl.start = w_accept && (t_op'(i_req.op) == OP_QUERY);
    assign w_side_p[0] = w_va;
    assign w_side_q[0] = w_vb;
    assign w_side_p[1] = w_vb;
    assign w_side_q[1] = w_vc;
    assign w_side_p[2] = w_vc;
    assign w_side_q[2] = w_va;

    assign w_flags[0] = '{valid: r_rd_valid, claimed: 1'b0, last: r_rd_last};
    assign w_edge[0]  = w_ram_rdata;
    assign w_idx[0]   = r_rd_idx;

    // Each edge visits side 0, then side 1, then side 2, one cell per cycle.
    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        if (k < NCELLS - 1) begin : g_mid
            tel_cell #(
                .VERTEX_BITS (VERTEX_BITS),
                .ADDR_W      (ADDR_W)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_side_p (w_side_p[k]),
                .i_side_q (w_side_q[k]),
                .i_flags  (w_flags[k]),
                .i_edge   (w_edge[k]),
                .i_idx    (w_idx[k]),
                .o_flags  (w_flags[k+1]),
                .o_edge   (w_edge[k+1]),
                .o_idx    (w_idx[k+1]),
                .o_found  (w_found[k]),
                .o_best   (w_best[k])
            );
        end else begin : g_tail
            // The last cell hands on only its flags, which mark the end of a scan.
            tel_cell #(
                .VERTEX_BITS (VERTEX_BITS),
                .ADDR_W      (ADDR_W)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_side_p (w_side_p[k]),
                .i_side_q (w_side_q[k]),
                .i_flags  (w_flags[k]),
                .i_edge   (w_edge[k]),
                .i_idx    (w_idx[k]),
                .o_flags  (w_flags[k+1]),
                .o_edge   (),
                .o_idx    (),
                .o_found  (w_found[k]),
                .o_best   (w_best[k])
            );
        end
    end

    assign w_tail_last = w_flags[NCELLS].valid && w_flags[NCELLS].last;

    // The result register takes a new result when it is empty or being drained.
    assign w_emit_load = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pend_ovf = r_pend_ovf;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_req.op))
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (w_full) begin
                                n_pend_ovf = 1'b1;
                                n_state    = S_EMIT;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            n_pend_ovf = 1'b0;
                            n_addr     = '0;
                            // An empty table answers with all sides not found.
                            n_state    = (r_count == '0) ? S_EMIT : S_SCAN;
                        end
                        default: begin
                            // The unused opcode is dropped without effect.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_addr = r_addr + ADDR_W'(1);
                if (w_scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (w_tail_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend_ovf  <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend_ovf <= n_pend_ovf;
            r_rd_valid <= (r_state == S_SCAN);
            if (w_emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_rd_last <= w_scan_last;
        r_rd_idx  <= r_addr;
        if (w_emit_load) begin
            r_out_ovf <= r_pend_ovf;
            for (int k = 0; k < NCELLS; k++) begin
                // Indices wider than the result field keep their low bits.
                r_out_edge[k]  <= r_pend_ovf ? '0 : IDX_W'(w_best[k]);
                r_out_found[k] <= r_pend_ovf ? 1'b0 : w_found[k];
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.side0_edge  = r_out_edge[0];
    assign o_rsp.side1_edge  = r_out_edge[1];
    assign o_rsp.side2_edge  = r_out_edge[2];
    assign o_rsp.side0_found = r_out_found[0];
    assign o_rsp.side1_found = r_out_found[1];
    assign o_rsp.side2_found = r_out_found[2];
    assign o_rsp.overflow    = r_out_ovf;

    `TEL_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_EDGES), "edge count beyond table capacity")

    `TEL_ASSERT_NXT(a_full_append_flags, i_clk, i_rst_n,
        w_accept && (i_req.op == OP_APPEND) && w_full,
        (r_state == S_EMIT) && r_pend_ovf && (r_count == CNT_W'(MAX_EDGES)),
        "append to a full table did not raise overflow")

    `TEL_ASSERT_IMP(a_token_in_scan, i_clk, i_rst_n, r_rd_valid,
        (r_state == S_SCAN) || (r_state == S_FLUSH), "edge entered chain outside a scan")

    `TEL_ASSERT_IMP(a_overflow_clean, i_clk, i_rst_n, r_out_valid && r_out_ovf,
        (r_out_found == '0) && (r_out_edge[0] == '0), "overflow result carries a match")

endmodule
